### hw/rtl/set_assoc_lru_cache_sim_top_assert.svh
`ifndef SET_ASSOC_LRU_CACHE_SIM_TOP_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_TOP_ASSERT_SVH

// clocked check, off while in reset
`define SALC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("salc check failed");

// clocked check, also held during reset
`define SALC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("salc check failed");

`endif

### hw/rtl/salc_pkg.sv
package salc_pkg;

  localparam logic [1:0] CMD_FETCH  = 2'd0;
  localparam logic [1:0] CMD_MODIFY = 2'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
  } way_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic rd;
    logic scan;
    logic wr;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_fetch;
    logic two_lookups;
    logic scan_hit;
    logic scan_last;
  } dp_sts_t;

endpackage

### hw/rtl/salc_if.sv
interface salc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] address;

  modport source (output valid, cmd, address, input ready);
  modport sink (input valid, cmd, address, output ready);
endinterface

interface salc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  hits_now;
  logic        misses_now;
  logic        evictions_now;
  logic [31:0] total_hits;
  logic [31:0] total_misses;
  logic [31:0] total_evictions;

  modport source (output valid, hits_now, misses_now, evictions_now, total_hits,
                  total_misses, total_evictions, input ready);
  modport sink (input valid, hits_now, misses_now, evictions_now, total_hits,
                total_misses, total_evictions, output ready);
endinterface

### hw/rtl/salc_ctrl.sv
module salc_ctrl
  import salc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    second_d    = second_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          second_d      = 1'b0;
          state_d       = sts_i.in_fetch ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_last) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.wr = 1'b1;
        if (sts_i.two_lookups && !second_q) begin
          second_d = 1'b1;
          state_d  = ST_READ;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/salc_dp.sv
module salc_dp
  import salc_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]            in_cmd_i,
  input  logic [31:0]           in_address_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  output logic [1:0]            hits_now_o,
  output logic                  misses_now_o,
  output logic                  evictions_now_o,
  output logic [31:0]           total_hits_o,
  output logic [31:0]           total_misses_o,
  output logic [31:0]           total_evictions_o
);

  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef way_t [MAX_WAYS-1:0] row_t;

  row_t mem [NUM_SETS];
  row_t row_q;
  row_t row_new;

  logic [2:0]       set_bits_q;
  logic [4:0]       off_q;
  logic [3:0]       ways_q;
  logic [SET_W-1:0] clr_cnt_q;

  logic [1:0]       cmd_q;
  logic [SET_W-1:0] set_q;
  logic [31:0]      tag_q;

  logic [31:0] stamp_q;
  logic [31:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [1:0]  hits_now_q;
  logic        miss_now_q, evict_now_q;

  logic [WAY_W-1:0] way_q, hit_way_q, free_way_q, victim_q;
  logic             found_hit_q, have_free_q, found_old_q;
  logic [31:0]      best_age_q;

  logic [2:0]       sb_eff;
  logic [SET_W-1:0] set_mask;
  logic [31:0]      addr_sh;
  logic [5:0]       tag_sh;
  logic [SET_W-1:0] set_d;
  logic [31:0]      tag_d;
  logic [WAY_W-1:0] last_way;
  logic [WAY_W-1:0] sel_way;
  way_t             cur;
  logic [31:0]      cur_age;
  logic             cur_hit;

  // set index and tag of the incoming request
  always_comb begin
    if (32'(set_bits_q) > MAX_SET_BITS) sb_eff = 3'(MAX_SET_BITS);
    else sb_eff = set_bits_q;
    for (int i = 0; i < SET_W; i++) set_mask[i] = (i < int'(sb_eff));
    addr_sh = in_address_i >> off_q;
    set_d   = addr_sh[SET_W-1:0] & set_mask;
    tag_sh  = {1'b0, off_q} + {3'b000, sb_eff};
    tag_d   = tag_sh[5] ? 32'd0 : (in_address_i >> tag_sh[4:0]);
  end

  always_comb begin
    if (ways_q == 4'd0) last_way = '0;
    else if (32'(ways_q) > MAX_WAYS) last_way = WAY_W'(MAX_WAYS - 1);
    else last_way = WAY_W'(ways_q - 4'd1);
  end

  assign cur     = row_q[way_q];
  assign cur_age = stamp_q - cur.stamp;
  assign cur_hit = cur.valid && (cur.tag == tag_q);

  always_comb begin
    if (found_hit_q) sel_way = hit_way_q;
    else if (have_free_q) sel_way = free_way_q;
    else sel_way = victim_q;
    row_new          = row_q;
    row_new[sel_way] = '{valid: 1'b1, tag: tag_q, stamp: stamp_q};
  end

  assign sts_o.clr_last    = (clr_cnt_q == SET_W'(NUM_SETS - 1));
  assign sts_o.in_fetch    = (in_cmd_i == CMD_FETCH);
  assign sts_o.two_lookups = (cmd_q == CMD_MODIFY);
  assign sts_o.scan_hit    = cur_hit;
  assign sts_o.scan_last   = (way_q == last_way);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) mem[clr_cnt_q] <= '0;
    else if (cmd_i.wr) mem[set_q] <= row_new;
    if (cmd_i.rd) row_q <= mem[set_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd4;
      off_q      <= 5'd4;
      ways_q     <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS:    set_bits_q <= cfg_data_i[2:0];
        CFG_OFFSET_BITS: off_q      <= cfg_data_i;
        CFG_WAYS:        ways_q     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      stamp_q     <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + SET_W'(1);
      if (cmd_i.rd) stamp_q <= stamp_q + 32'd1;
      if (cmd_i.wr) begin
        if (found_hit_q) begin
          hit_cnt_q <= hit_cnt_q + 32'd1;
        end else begin
          miss_cnt_q <= miss_cnt_q + 32'd1;
          if (!have_free_q) evict_cnt_q <= evict_cnt_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q       <= in_cmd_i;
      set_q       <= set_d;
      tag_q       <= tag_d;
      hits_now_q  <= 2'd0;
      miss_now_q  <= 1'b0;
      evict_now_q <= 1'b0;
    end
    if (cmd_i.wr) begin
      if (found_hit_q) begin
        hits_now_q <= hits_now_q + 2'd1;
      end else begin
        miss_now_q <= 1'b1;
        if (!have_free_q) evict_now_q <= 1'b1;
      end
    end
    if (cmd_i.rd) begin
      way_q       <= '0;
      found_hit_q <= 1'b0;
      have_free_q <= 1'b0;
      found_old_q <= 1'b0;
      best_age_q  <= '0;
    end
    if (cmd_i.scan) begin
      way_q <= way_q + WAY_W'(1);
      if (cur_hit) begin
        found_hit_q <= 1'b1;
        hit_way_q   <= way_q;
      end else if (!cur.valid) begin
        if (!have_free_q) begin
          have_free_q <= 1'b1;
          free_way_q  <= way_q;
        end
      end else if (!found_old_q || cur_age > best_age_q) begin
        found_old_q <= 1'b1;
        best_age_q  <= cur_age;
        victim_q    <= way_q;
      end
    end
    if (cmd_i.load_out) begin
      hits_now_o        <= hits_now_q;
      misses_now_o      <= miss_now_q;
      evictions_now_o   <= evict_now_q;
      total_hits_o      <= hit_cnt_q;
      total_misses_o    <= miss_cnt_q;
      total_evictions_o <= evict_cnt_q;
    end
  end

endmodule

### hw/rtl/set_assoc_lru_cache_sim_top.sv
// channel  | dir | handshake     | payload
// in_if    | in  | valid / ready | cmd, address
// out_if   | out | valid / ready | hits_now, misses_now, evictions_now, total_*
// cfg      | in  | cfg_we_i      | cfg_idx_i, cfg_data_i
// a fetch goes from accept straight to DONE, with no lookup and no counter update
// a load or store runs READ, SCAN over k ways (1 to ways in use), WRITE, then DONE
// a modify runs two lookups back to back: READ, SCAN and WRITE twice, then DONE
// one way a cycle through the set row read from the single-port tag memory
// after reset a clearing pass zeroes all 2^MAX_SET_BITS set rows before any request
// a request is taken while an earlier result still waits on out_if
module set_assoc_lru_cache_sim_top
  import salc_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  salc_in_if.sink               in_if,
  salc_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  salc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_cmd_i          (in_if.cmd),
    .in_address_i      (in_if.address),
    .cmd_i             (dp_cmd),
    .sts_o             (dp_sts),
    .hits_now_o        (out_if.hits_now),
    .misses_now_o      (out_if.misses_now),
    .evictions_now_o   (out_if.evictions_now),
    .total_hits_o      (out_if.total_hits),
    .total_misses_o    (out_if.total_misses),
    .total_evictions_o (out_if.total_evictions)
  );

endmodule

### hw/rtl/salc_checker.sv
`include "set_assoc_lru_cache_sim_top_assert.svh"

module salc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] hits_now_i,
  input logic       misses_now_i,
  input logic       evictions_now_i
);

  // result held until taken
  `SALC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  // one request at a time: busy right after an accept
  `SALC_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)

  // eviction only on a miss, at most two lookups per request
  `SALC_ASSERT(a_event_mix, clk_i, rst_ni,
    out_valid_i |-> (!evictions_now_i || misses_now_i) && (hits_now_i != 2'd3) &&
      !(hits_now_i == 2'd2 && misses_now_i))

  // nothing offered or taken once reset has been seen at an edge
  `SALC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !in_ready_i && !out_valid_i)

endmodule

bind set_assoc_lru_cache_sim_top salc_checker u_salc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .hits_now_i      (out_if.hits_now),
  .misses_now_i    (out_if.misses_now),
  .evictions_now_i (out_if.evictions_now)
);
